FILE: hw/rtl/nie_pkg.sv
// ----------------------------------------------------------------------------
// nie_pkg
// Shared types and constants of the Newton interpolation engine.
// ----------------------------------------------------------------------------
package nie_pkg;

  localparam int MAX_NODES = 16;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = IDX_W + 1;
  localparam int DATA_W    = 32;
  localparam int SPACE_W   = 31;
  localparam int DIFF_W    = DATA_W + 1;
  localparam int FRAC_W    = 16;
  localparam int QUO_W     = DIFF_W + FRAC_W;
  localparam int PROD_W    = DATA_W + DIFF_W;
  localparam int SUM_W     = PROD_W - FRAC_W + 1;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DEGEN  = 2'd1;
  localparam logic [1:0] ST_NOCOEF = 2'd2;
  localparam logic [1:0] ST_OVF    = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_LOAD_LAST,
    OP_EVAL
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_BSTART,
    S_BRD,
    S_BCHK,
    S_BDIV,
    S_BWR,
    S_ESTART,
    S_EP0,
    S_EP1,
    S_ERD,
    S_EMUL,
    S_EACC,
    S_FIN
  } state_t;

endpackage

FILE: hw/rtl/nie_front.sv
// ----------------------------------------------------------------------------
// nie_front
// Accepts input transactions, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module nie_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          command,
  input  logic signed [31:0]            point_x,
  input  logic signed [31:0]            point_y,
  input  logic                          last_node,
  input  logic signed [31:0]            query_point,
  input  logic                          pop,
  output nie_pkg::q_head_t              head
);
  import nie_pkg::*;

  item_t             entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  item_t             new_item;
  logic              push;
  logic              take;

  always_comb begin
    new_item.op = command ? OP_EVAL : (last_node ? OP_LOAD_LAST : OP_LOAD);
    new_item.x  = point_x;
    new_item.y  = point_y;
    new_item.z  = query_point;
  end

  assign in_stall   = (count == QCNT_W'(QDEPTH));
  assign push       = in_valid && !in_stall;
  assign take       = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(take);
    end
  end

endmodule

FILE: hw/rtl/nie_div.sv
// ----------------------------------------------------------------------------
// nie_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nie_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [nie_pkg::QUO_W-1:0]   dividend,
  input  logic [nie_pkg::DIFF_W-1:0]  divisor,
  output logic                        done,
  output logic [nie_pkg::QUO_W-1:0]   quotient
);
  import nie_pkg::*;

  localparam int STEP_W = $clog2(QUO_W + 1);

  logic [DIFF_W-1:0] rem;
  logic [DIFF_W-1:0] dvs;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [DIFF_W:0]   trial;
  logic              fits;

  assign trial = {rem, quotient[QUO_W-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? DIFF_W'(trial - {1'b0, dvs}) : trial[DIFF_W-1:0];
      quotient <= {quotient[QUO_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(QUO_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/nie_back.sv
// ----------------------------------------------------------------------------
// nie_back
// Executes queued transactions: node stores, coefficient build and evaluation.
// ----------------------------------------------------------------------------
module nie_back (
  input  logic                         clk,
  input  logic                         rst,
  input  nie_pkg::q_head_t             head,
  output logic                         pop,
  input  logic                         cfg_we,
  input  logic [nie_pkg::SPACE_W-1:0]  cfg_wdata,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [31:0]           poly_value,
  output logic [1:0]                   status
);
  import nie_pkg::*;

  localparam logic [QUO_W-1:0] POS_LIM = {{(QUO_W-DATA_W){1'b0}}, 32'h7FFF_FFFF};
  localparam logic [QUO_W-1:0] NEG_LIM = {{(QUO_W-DATA_W){1'b0}}, 32'h8000_0000};

  state_t state, state_next;

  logic [SPACE_W-1:0]       min_spacing;
  logic [CNT_W-1:0]         node_count;
  logic                     coef_ready;
  logic [IDX_W-1:0]         idx_i;
  logic [IDX_W-1:0]         idx_k;
  logic [IDX_W-1:0]         top_n;
  item_t                    cur;
  logic                     ovf;
  logic signed [DATA_W-1:0] p_acc;
  logic signed [DATA_W-1:0] c_hold;
  logic signed [PROD_W-1:0] prod;
  logic signed [DATA_W-1:0] res_value;
  logic [1:0]               res_status;

  logic signed [DATA_W-1:0] x_mem [MAX_NODES];
  logic signed [DATA_W-1:0] c_mem [MAX_NODES];
  logic signed [DATA_W-1:0] xa, xb, ca, cb;
  logic [IDX_W-1:0]         x_ra0, x_ra1, c_ra0, c_ra1, w_addr;
  logic                     x_we, c_we;
  logic signed [DATA_W-1:0] c_wdata;

  logic [CNT_W-1:0]         eff_cnt;
  logic                     load_room;
  logic [CNT_W-1:0]         new_cnt;

  logic signed [DIFF_W-1:0] den;
  logic [DIFF_W-1:0]        den_mag;
  logic signed [DIFF_W-1:0] num;
  logic [DIFF_W-1:0]        num_mag;
  logic                     degen;
  logic                     div_start;
  logic                     div_done;
  logic [QUO_W-1:0]         div_q;
  logic                     div_neg;
  logic signed [DATA_W-1:0] div_val;
  logic                     div_ovf;

  logic signed [DIFF_W-1:0] ediff;
  logic signed [SUM_W-2:0]  shq;
  logic signed [SUM_W-1:0]  esum;
  logic signed [DATA_W-1:0] esat;
  logic                     e_ovf;
  logic                     out_free;

  // Memory addresses follow the loop indices directly.
  assign x_ra0 = idx_i;
  assign x_ra1 = idx_i - idx_k;
  assign c_ra0 = idx_i;
  assign c_ra1 = idx_i - 1'b1;

  assign eff_cnt   = coef_ready ? '0 : node_count;
  assign load_room = (eff_cnt < CNT_W'(MAX_NODES));
  assign new_cnt   = eff_cnt + CNT_W'(load_room);
  assign out_free  = !out_valid || !out_stall;

  // Divided difference operands.
  always_comb begin
    den     = DIFF_W'(xa) - DIFF_W'(xb);
    den_mag = den[DIFF_W-1] ? DIFF_W'(-den) : den;
    num     = DIFF_W'(ca) - DIFF_W'(cb);
    num_mag = num[DIFF_W-1] ? DIFF_W'(-num) : num;
    degen   = !(den_mag > {2'b00, min_spacing});
  end

  nie_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({num_mag, {FRAC_W{1'b0}}}),
    .divisor  (den_mag),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sign and saturation of the quotient.
  always_comb begin
    div_ovf = 1'b0;
    div_val = div_q[DATA_W-1:0];
    if (div_neg) begin
      if (div_q > NEG_LIM) begin
        div_ovf = 1'b1;
        div_val = 32'sh8000_0000;
      end else begin
        div_val = -div_q[DATA_W-1:0];
      end
    end else if (div_q > POS_LIM) begin
      div_ovf = 1'b1;
      div_val = 32'sh7FFF_FFFF;
    end
  end

  // Horner step: truncate the product toward zero, add, saturate.
  always_comb begin
    ediff = DIFF_W'(cur.z) - DIFF_W'(xa);
    shq   = prod[PROD_W-1:FRAC_W];
    if (prod[PROD_W-1] && (prod[FRAC_W-1:0] != '0)) begin
      shq = shq + 1'b1;
    end
    esum  = SUM_W'(shq) + SUM_W'(c_hold);
    e_ovf = (esum[SUM_W-1:DATA_W-1] != '0) && (esum[SUM_W-1:DATA_W-1] != '1);
    if (e_ovf) begin
      esat = esum[SUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      esat = esum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (x_we) begin
      x_mem[w_addr] <= cur.x;
    end
    if (c_we) begin
      c_mem[w_addr] <= c_wdata;
    end
    xa <= x_mem[x_ra0];
    xb <= x_mem[x_ra1];
    ca <= c_mem[c_ra0];
    cb <= c_mem[c_ra1];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (head.valid) begin
          state_next = (head.item.op == OP_EVAL) ? S_ESTART : S_LOAD;
        end
      end
      S_LOAD:   state_next = (cur.op == OP_LOAD_LAST) ? S_BSTART : S_IDLE;
      S_BSTART: state_next = (top_n == '0) ? S_FIN : S_BRD;
      S_BRD:    state_next = S_BCHK;
      S_BCHK:   state_next = degen ? S_FIN : S_BDIV;
      S_BDIV:   state_next = div_done ? S_BWR : S_BDIV;
      S_BWR: begin
        if ((idx_i == idx_k) && (idx_k == top_n)) begin
          state_next = S_FIN;
        end else begin
          state_next = S_BRD;
        end
      end
      S_ESTART: state_next = (!coef_ready || node_count == '0) ? S_FIN : S_EP0;
      S_EP0:    state_next = S_EP1;
      S_EP1:    state_next = (idx_i == '0) ? S_FIN : S_ERD;
      S_ERD:    state_next = S_EMUL;
      S_EMUL:   state_next = S_EACC;
      S_EACC:   state_next = (idx_i == '0) ? S_FIN : S_ERD;
      S_FIN:    state_next = out_free ? S_IDLE : S_FIN;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    x_we      = 1'b0;
    c_we      = 1'b0;
    w_addr    = idx_i;
    c_wdata   = div_val;
    div_start = 1'b0;
    case (state)
      S_IDLE: pop = head.valid;
      S_LOAD: begin
        x_we    = load_room;
        c_we    = load_room;
        w_addr  = eff_cnt[IDX_W-1:0];
        c_wdata = cur.y;
      end
      S_BCHK: div_start = !degen;
      S_BWR:  c_we = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: cur <= head.item;
      S_LOAD: top_n <= IDX_W'(new_cnt - 1'b1);
      S_BSTART: begin
        idx_k      <= IDX_W'(1);
        idx_i      <= top_n;
        res_value  <= '0;
        res_status <= ST_OK;
      end
      S_BCHK: begin
        div_neg    <= num[DIFF_W-1] ^ den[DIFF_W-1];
        res_status <= ST_DEGEN;
      end
      S_BWR: begin
        res_status <= (ovf || div_ovf) ? ST_OVF : ST_OK;
        if (idx_i == idx_k) begin
          idx_k <= idx_k + 1'b1;
          idx_i <= top_n;
        end else begin
          idx_i <= idx_i - 1'b1;
        end
      end
      S_ESTART: begin
        idx_i      <= IDX_W'(node_count - 1'b1);
        res_value  <= '0;
        res_status <= ST_NOCOEF;
      end
      S_EP1: begin
        p_acc      <= ca;
        res_value  <= ca;
        res_status <= ST_OK;
        idx_i      <= idx_i - 1'b1;
      end
      S_EMUL: begin
        prod   <= p_acc * ediff;
        c_hold <= ca;
      end
      S_EACC: begin
        p_acc      <= esat;
        res_value  <= esat;
        res_status <= (ovf || e_ovf) ? ST_OVF : ST_OK;
        idx_i      <= idx_i - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      min_spacing <= SPACE_W'(1);
      node_count  <= '0;
      coef_ready  <= 1'b0;
      ovf         <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        min_spacing <= cfg_wdata;
      end
      case (state)
        S_LOAD: begin
          node_count <= new_cnt;
          coef_ready <= 1'b0;
        end
        S_BSTART: begin
          ovf <= 1'b0;
          if (top_n == '0) begin
            coef_ready <= 1'b1;
          end
        end
        S_BCHK: begin
          if (degen) begin
            node_count <= '0;
            coef_ready <= 1'b0;
          end
        end
        S_BWR: begin
          ovf <= ovf || div_ovf;
          if ((idx_i == idx_k) && (idx_k == top_n)) begin
            coef_ready <= 1'b1;
          end
        end
        S_ESTART: ovf <= 1'b0;
        S_EACC:   ovf <= ovf || e_ovf;
        default: begin
        end
      endcase
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      poly_value <= res_value;
      status     <= res_status;
    end
  end

endmodule

FILE: hw/rtl/newton_interpolation_engine_core.sv
// ----------------------------------------------------------------------------
// newton_interpolation_engine_core
// Newton divided-difference interpolation in signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Items enter a two-deep queue and are executed one at a time by a sequencer
// around two 16-entry node memories, a radix-2 divider and a single
// 32x33 multiplier. The coefficient build after the last node runs one
// division per divided difference, n(n-1)/2 of them for n nodes, so the
// divider sets its length. An evaluation runs a multiply and accumulate
// loop over the coefficients. A finished result sits in an output register,
// so the front end keeps accepting transactions while the result waits to
// be taken, as long as the queue has room.
module newton_interpolation_engine_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         command,
  input  logic signed [31:0]           point_x,
  input  logic signed [31:0]           point_y,
  input  logic                         last_node,
  input  logic signed [31:0]           query_point,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [31:0]           poly_value,
  output logic [1:0]                   status,
  input  logic                         cfg_we,
  input  logic [nie_pkg::SPACE_W-1:0]  cfg_wdata
);
  import nie_pkg::*;

  q_head_t head;
  logic    pop;

  nie_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .point_x     (point_x),
    .point_y     (point_y),
    .last_node   (last_node),
    .query_point (query_point),
    .pop         (pop),
    .head        (head)
  );

  nie_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .pop        (pop),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .poly_value (poly_value),
    .status     (status)
  );

endmodule
